@@ src/qkd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the quadrature step table for the knob decoder.
// Used by qkd_step and quadrature_knob_decoder; depends on nothing else.
package qkd_pkg;

	localparam int unsigned READING_W = 3;
	localparam int unsigned COUNT_W   = 32;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 72;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_REPORT = 2'd1,
		OP_LOAD   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		DIR_NONE    = 2'd0,
		DIR_FWD     = 2'd1,
		DIR_REV     = 2'd2,
		DIR_UNKNOWN = 2'd3
	} dir_t;

	typedef struct packed {
		logic [READING_W-1:0]      last_reading;
		dir_t                      step_dir;
		logic signed [COUNT_W-1:0] click_count;
		logic signed [COUNT_W-1:0] reported_count;
		logic                      pressed_now;
		logic                      pressed_at_report;
	} qkd_state_t;

	typedef struct packed {
		logic                      release_event;
		logic                      press_event;
		logic                      button_down;
		dir_t                      direction;
		logic signed [COUNT_W-1:0] click_total;
		logic signed [COUNT_W-1:0] click_delta;
	} qkd_result_t;

	localparam qkd_state_t STATE_RESET = '{
		last_reading:      '0,
		step_dir:          DIR_UNKNOWN,
		click_count:       '0,
		reported_count:    '0,
		pressed_now:       1'b1,
		pressed_at_report: 1'b1
	};

	// Direction indexed by old phases in the upper two bits, new phases below.
	localparam dir_t STEP_TABLE [0:15] = '{
		DIR_NONE,    DIR_FWD,     DIR_REV,     DIR_UNKNOWN,
		DIR_REV,     DIR_NONE,    DIR_UNKNOWN, DIR_FWD,
		DIR_FWD,     DIR_UNKNOWN, DIR_NONE,    DIR_REV,
		DIR_UNKNOWN, DIR_REV,     DIR_FWD,     DIR_NONE
	};

endpackage

@@ src/qkd_step.sv @@
`timescale 1ns / 1ps
// Combinational update of the knob state for one item and the matching result.
// Depends on qkd_pkg for the state, result and code types.
module qkd_step import qkd_pkg::*; (
	input  logic [1:0]           operation,
	input  logic [READING_W-1:0] reading,
	input  qkd_state_t           state,
	output qkd_state_t           state_next,
	output qkd_result_t          result
);

	dir_t step;
	logic pressed_in;

	assign step       = STEP_TABLE[{state.last_reading[1:0], reading[1:0]}];
	assign pressed_in = ~reading[2];

	always_comb begin
		state_next           = state;
		result.click_delta   = '0;
		result.press_event   = 1'b0;
		result.release_event = 1'b0;
		unique case (operation)
			OP_SAMPLE: begin
				unique case (step)
					DIR_FWD: begin
						if (state.step_dir == DIR_FWD) begin
							state_next.click_count = state.click_count + 32'sd1;
						end
						state_next.step_dir     = DIR_FWD;
						state_next.last_reading = reading;
					end
					DIR_REV: begin
						if (state.step_dir == DIR_REV) begin
							state_next.click_count = state.click_count - 32'sd1;
						end
						state_next.step_dir     = DIR_REV;
						state_next.last_reading = reading;
					end
					DIR_UNKNOWN: begin
						state_next.step_dir     = DIR_UNKNOWN;
						state_next.last_reading = reading;
					end
					default: begin
					end
				endcase
				state_next.pressed_now = pressed_in;
			end
			OP_REPORT: begin
				result.click_delta           = state.click_count - state.reported_count;
				state_next.reported_count    = state.click_count;
				result.press_event           = state.pressed_now & ~state.pressed_at_report;
				result.release_event         = ~state.pressed_now & state.pressed_at_report;
				state_next.pressed_at_report = state.pressed_now;
			end
			OP_LOAD: begin
				state_next.last_reading      = reading;
				state_next.step_dir          = DIR_UNKNOWN;
				state_next.click_count       = '0;
				state_next.reported_count    = '0;
				state_next.pressed_now       = pressed_in;
				state_next.pressed_at_report = pressed_in;
			end
			default: begin
			end
		endcase
		result.click_total = state_next.click_count;
		result.direction   = state_next.step_dir;
		result.button_down = state_next.pressed_now;
	end

endmodule

@@ src/quadrature_knob_decoder.sv @@
`timescale 1ns / 1ps
// Rotary knob decoder: takes one item per clock while the output is not stalled and
// returns one result per item. An item first lands in an input register; the knob
// state is then updated and the result is written to an output register once that
// register is free or being read, so the state update loop sets the rate of one
// item per clock. The input side keeps accepting while a result waits in the output
// register, and stalls only when both registers are held. Depends on qkd_pkg
// and qkd_step.
module quadrature_knob_decoder import qkd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0: operation[1:0], reading[4:2], zero fill [7:5].
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Fields from bit 0: click_delta[31:0], click_total[63:32], direction[65:64],
	// button_down[66], press_event[67], release_event[68], zero fill [71:69].
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic                 valid_s1;
	logic [1:0]           operation_s1;
	logic [READING_W-1:0] reading_s1;
	logic                 out_valid_q;
	qkd_result_t          result_q;
	qkd_state_t           state_q;
	qkd_state_t           state_next;
	qkd_result_t          result;
	logic                 advance;
	logic                 in_accept;

	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;
	assign in_accept     = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			operation_s1 <= s_axis_tdata[1:0];
			reading_s1   <= s_axis_tdata[4:2];
		end
	end

	qkd_step u_step (
		.operation  (operation_s1),
		.reading    (reading_s1),
		.state      (state_q),
		.state_next (state_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, result_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.press_event && result_q.release_event))
		else $error("Press and release reported together.");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && operation_s1 == OP_SAMPLE |=>
			(state_q.click_count == $past(state_q.click_count)) ||
			(state_q.click_count == $past(state_q.click_count) + 32'sd1) ||
			(state_q.click_count == $past(state_q.click_count) - 32'sd1))
		else $error("Sample moved the click count by more than one.");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && operation_s1 == OP_REPORT |=>
			state_q.reported_count == state_q.click_count &&
			result_q.click_total == state_q.click_count)
		else $error("Report did not move the count baseline.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("Input stalled while the output register is empty.");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && operation_s1 == OP_LOAD |=>
			state_q.step_dir == DIR_UNKNOWN && state_q.click_count == '0 &&
			state_q.pressed_now == state_q.pressed_at_report)
		else $error("Load did not restart the knob state.");

endmodule
